>>> rtl/metr_pkg.sv
// shared constants and types for the manchester edge timing receiver
package metr_pkg;

    localparam int COUNT_WIDTH      = 16;
    localparam int BITS_PER_FRAME   = 8;
    localparam int BIT_COUNT_WIDTH  = $clog2(BITS_PER_FRAME + 1);
    localparam int CFG_DATA_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int BYTE_WIDTH       = 8;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELOAD_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LATE_BOUND    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRAP_BOUND    = 2'd2;

    // register reset values
    localparam logic [COUNT_WIDTH-1:0] RELOAD_PERIOD_RESET = 16'd10;
    localparam logic [COUNT_WIDTH-1:0] LATE_BOUND_RESET    = 16'd8;
    localparam logic [COUNT_WIDTH-1:0] WRAP_BOUND_RESET    = 16'd2;

    // item kinds
    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_EDGE = 1'b1;

    typedef logic [COUNT_WIDTH-1:0]     count_t;
    typedef logic [BIT_COUNT_WIDTH-1:0] bit_count_t;
    typedef logic [BITS_PER_FRAME-1:0]  frame_t;

    typedef struct packed {
        logic                  bit_taken;
        logic                  bit_value;
        logic                  byte_ready;
        logic [BYTE_WIDTH-1:0] byte_value;
    } result_t;

endpackage

>>> rtl/metr_if.sv
// valid/ready channels for input items and result items

interface metr_item_if;
    logic valid;
    logic ready;
    logic action;
    logic line_level;

    modport source (output valid, output action, output line_level, input ready);
    modport sink   (input valid, input action, input line_level, output ready);
endinterface

interface metr_result_if
    import metr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  bit_taken;
    logic                  bit_value;
    logic                  byte_ready;
    logic [BYTE_WIDTH-1:0] byte_value;

    modport source (output valid, output bit_taken, output bit_value,
                    output byte_ready, output byte_value, input ready);
    modport sink   (input valid, input bit_taken, input bit_value,
                    input byte_ready, input byte_value, output ready);
endinterface

>>> rtl/manchester_edge_timing_receiver_core.sv
// manchester edge timing receiver: tick counter, edge qualifier and byte assembler
// each accepted item's result is written into the output register
// throughput: one item per cycle; a new item is taken whenever the output register
//   is empty or its result is taken in the same cycle
// reset (rst_n low, asynchronous): counter, bit count and shift cleared, block armed
//   for a first edge, registers back to reload 10, late bound 8, wrap bound 2
module manchester_edge_timing_receiver_core
    import metr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    metr_item_if.sink                  items,
    metr_result_if.source              results
);

    // configuration registers
    count_t reload_period_reg;
    count_t late_bound_reg;
    count_t wrap_bound_reg;

    // receiver state
    count_t     tick_count_reg,      tick_count_next;
    logic       first_armed_reg,     first_armed_next;
    logic       trailing_pending_reg, trailing_pending_next;
    bit_count_t bit_count_reg,       bit_count_next;
    frame_t     byte_shift_reg,      byte_shift_next;

    // output register
    logic    out_valid_reg;
    result_t out_data_reg, out_data_next;

    logic       item_accept;
    logic       edge_taken;
    bit_count_t bit_count_inc;
    frame_t     shift_in;
    logic       frame_done;

    // output register frees up when empty or drained this cycle
    assign items.ready = !out_valid_reg || results.ready;
    assign item_accept = items.valid && items.ready;

    // plain write port, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_period_reg <= RELOAD_PERIOD_RESET;
            late_bound_reg    <= LATE_BOUND_RESET;
            wrap_bound_reg    <= WRAP_BOUND_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RELOAD_PERIOD: reload_period_reg <= cfg_data;
                REG_LATE_BOUND:    late_bound_reg    <= cfg_data;
                REG_WRAP_BOUND:    wrap_bound_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // edge qualifier: first edge of a frame, late edge, or edge just past a wrap
    assign edge_taken = first_armed_reg
                     || (tick_count_reg >= late_bound_reg)
                     || (tick_count_reg <= wrap_bound_reg);

    assign bit_count_inc = bit_count_reg + bit_count_t'(1);
    assign shift_in      = {byte_shift_reg[BITS_PER_FRAME-2:0], items.line_level};
    // the count only reaches a full frame on a taken edge
    assign frame_done    = edge_taken && (bit_count_inc == bit_count_t'(BITS_PER_FRAME));

    always_comb
    begin
        tick_count_next       = tick_count_reg;
        first_armed_next      = first_armed_reg;
        trailing_pending_next = trailing_pending_reg;
        bit_count_next        = bit_count_reg;
        byte_shift_next       = byte_shift_reg;
        out_data_next         = '0;

        if (items.action == ACTION_TICK)
        begin
            // wrap at the reload value, also when the count sits above a lowered reload
            if (tick_count_reg >= reload_period_reg)
                tick_count_next = '0;
            else
                tick_count_next = tick_count_reg + count_t'(1);
        end
        else
        begin
            if (edge_taken)
            begin
                out_data_next.bit_taken = 1'b1;
                out_data_next.bit_value = items.line_level;
                byte_shift_next         = shift_in;
                bit_count_next          = bit_count_inc;
                first_armed_next        = 1'b0;
                tick_count_next         = '0;
            end

            // the swallowed trailing edge re-arms the block, taken or not
            if (trailing_pending_reg)
            begin
                first_armed_next      = 1'b1;
                trailing_pending_next = 1'b0;
            end

            if (frame_done)
            begin
                out_data_next.byte_ready = 1'b1;
                out_data_next.byte_value = BYTE_WIDTH'(shift_in);
                // frame ending in 1 re-arms now, ending in 0 waits one more edge
                if (items.line_level)
                begin
                    first_armed_next      = 1'b1;
                    trailing_pending_next = 1'b0;
                end
                else
                begin
                    trailing_pending_next = 1'b1;
                end
                bit_count_next  = '0;
                byte_shift_next = '0;
            end
        end
    end

    // state advances only on accepted items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg       <= '0;
            first_armed_reg      <= 1'b1;
            trailing_pending_reg <= 1'b0;
            bit_count_reg        <= '0;
            byte_shift_reg       <= '0;
        end
        else if (item_accept)
        begin
            tick_count_reg       <= tick_count_next;
            first_armed_reg      <= first_armed_next;
            trailing_pending_reg <= trailing_pending_next;
            bit_count_reg        <= bit_count_next;
            byte_shift_reg       <= byte_shift_next;
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item_accept)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_accept)
            out_data_reg <= out_data_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.bit_taken  = out_data_reg.bit_taken;
    assign results.bit_value  = out_data_reg.bit_value;
    assign results.byte_ready = out_data_reg.byte_ready;
    assign results.byte_value = out_data_reg.byte_value;

endmodule

>>> tb/sv/manchester_edge_timing_receiver_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the manchester edge timing receiver core
module manchester_edge_timing_receiver_core_tb
    import metr_pkg::*;
;

    // stimulus size: about 1250 items spread over eight register settings
    localparam int ITEM_TARGET  = 1250;
    localparam int PHASE_ITEMS  = 125;
    // cycles without any accepted item on either channel before the run is abandoned
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_LIMIT = 10;
    // index with no register behind it, writes there must change nothing
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    // mirror of the receiver: timing rule, bit assembly and the queue of expected decodes
    class edge_decode_checker;
        count_t  reload_period;
        count_t  late_bound;
        count_t  wrap_bound;
        count_t  tick_count;
        bit      armed;
        bit      trailing_pending;
        int      bits_held;
        frame_t  shift_reg;
        result_t expected_decodes[$];
        int      mismatches;

        function new();
            reload_period    = RELOAD_PERIOD_RESET;
            late_bound       = LATE_BOUND_RESET;
            wrap_bound       = WRAP_BOUND_RESET;
            tick_count       = '0;
            armed            = 1'b1;
            trailing_pending = 1'b0;
            bits_held        = 0;
            shift_reg        = '0;
            mismatches       = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] index,
                                logic [CFG_DATA_WIDTH-1:0] data);
            case (index)
                REG_RELOAD_PERIOD: reload_period = data;
                REG_LATE_BOUND:    late_bound    = data;
                REG_WRAP_BOUND:    wrap_bound    = data;
                default: ;
            endcase
        endfunction

        // decode one accepted item and queue the result it must produce
        function void note_item(logic action, logic level);
            result_t want;
            want = '0;
            if (action == ACTION_TICK)
            begin
                if (tick_count >= reload_period)
                    tick_count = '0;
                else
                    tick_count = tick_count + 1'b1;
            end
            else
            begin
                if (armed || tick_count >= late_bound || tick_count <= wrap_bound)
                begin
                    want.bit_taken = 1'b1;
                    want.bit_value = level;
                    shift_reg      = {shift_reg[BITS_PER_FRAME-2:0], level};
                    bits_held      = bits_held + 1;
                    armed          = 1'b0;
                    tick_count     = '0;
                end
                if (trailing_pending)
                begin
                    armed            = 1'b1;
                    trailing_pending = 1'b0;
                end
                if (bits_held >= BITS_PER_FRAME)
                begin
                    want.byte_ready = 1'b1;
                    want.byte_value = shift_reg;
                    if (want.bit_taken && want.bit_value)
                    begin
                        armed            = 1'b1;
                        trailing_pending = 1'b0;
                    end
                    else
                        trailing_pending = 1'b1;
                    bits_held = 0;
                    shift_reg = '0;
                end
            end
            expected_decodes.push_back(want);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_decodes.size() == 0)
            begin
                report($sformatf("result with nothing expected: taken %0b bit %0b ready %0b byte %02h",
                                 got.bit_taken, got.bit_value, got.byte_ready, got.byte_value));
                return;
            end
            want = expected_decodes.pop_front();
            if (got.bit_taken !== want.bit_taken || got.bit_value !== want.bit_value ||
                got.byte_ready !== want.byte_ready || got.byte_value !== want.byte_value)
                report($sformatf({"decode mismatch: expected taken %0b bit %0b ready %0b byte %02h,",
                                  " got taken %0b bit %0b ready %0b byte %02h"},
                                 want.bit_taken, want.bit_value, want.byte_ready, want.byte_value,
                                 got.bit_taken, got.bit_value, got.byte_ready, got.byte_value));
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    metr_item_if   item_ch ();
    metr_result_if result_ch ();

    edge_decode_checker edge_decoder;
    int items_sent    = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 65;
    int quiet_cycles  = 0;

    manchester_edge_timing_receiver_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (item_ch),
        .results   (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver side: ready is redrawn every falling edge from the current stall rate
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // result monitor, samples at the rising edge before the block updates
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.bit_taken  = result_ch.bit_taken;
            got.bit_value  = result_ch.bit_value;
            got.byte_ready = result_ch.byte_ready;
            got.byte_value = result_ch.byte_value;
            edge_decoder.check_result(got);
        end
    end

    // watchdog: any handshake on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one item, hold it until accepted, return at the next falling edge
    // valid stays high on return so back-to-back items go out without a gap
    task automatic send_item(input logic action, input logic level);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= action;
        item_ch.line_level <= level;
        forever
        begin
            @(posedge clk);
            if (item_ch.ready)
                break;
        end
        edge_decoder.note_item(action, level);
        items_sent++;
        // idle schedule: sender light / receiver heavy, then swapped, then none
        if (items_sent < ITEM_TARGET / 3)
        begin
            send_idle_pct = 7;
            recv_idle_pct = 65;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 65;
            recv_idle_pct = 7;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge clk);
    endtask

    // level on a tick carries no meaning, so it is random
    task automatic send_ticks(input int count);
        repeat (count) send_item(ACTION_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_edge(input logic level);
        send_item(ACTION_EDGE, level);
    endtask

    // sender pause: drop valid and wait until every queued decode has come back
    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        while (edge_decoder.expected_decodes.size() != 0)
            @(negedge clk);
        // margin after the last result has been taken
        repeat (2) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        edge_decoder.write_reg(index, data);
        @(negedge clk);
    endtask

    // tick gap before an edge: aim just after a wrap, around the late bound, or anywhere
    // in the period; capped so large register values do not stretch the run
    function automatic int pick_gap();
        int rp;
        int lb;
        int wb;
        rp = int'(edge_decoder.reload_period);
        lb = int'(edge_decoder.late_bound);
        wb = int'(edge_decoder.wrap_bound);
        case ($urandom_range(0, 2))
            0: pick_gap = $urandom_range(0, (wb < 40) ? wb + 1 : 40);
            1: pick_gap = (lb < 40) ? $urandom_range((lb > 0) ? lb - 1 : 0, lb + 2)
                                    : $urandom_range(0, 40);
            default: pick_gap = $urandom_range(0, (rp < 39) ? rp + 2 : 40);
        endcase
    endfunction

    // a run of edges spaced by timed tick gaps, random line levels
    task automatic run_frame(input int edges);
        repeat (edges)
        begin
            send_ticks(pick_gap());
            send_edge(1'($urandom_range(0, 1)));
        end
    endtask

    // one register setting followed by its share of random traffic
    task automatic run_phase(input count_t reload, input count_t late, input count_t wrap);
        int start;
        int pick;
        wait_for_results();
        // lowering the period: first park the counter at the old period so it ends up
        // above the new one and the next tick must wrap it
        if (reload < edge_decoder.reload_period && edge_decoder.reload_period <= 64)
        begin
            while (edge_decoder.tick_count != edge_decoder.reload_period)
                send_item(ACTION_TICK, 1'($urandom_range(0, 1)));
            wait_for_results();
        end
        write_cfg(REG_RELOAD_PERIOD, reload);
        write_cfg(REG_LATE_BOUND, late);
        write_cfg(REG_WRAP_BOUND, wrap);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                // full frame, sometimes with extra edges that run into the trailing edge
                run_frame($urandom_range(8, 11));
            else if (pick < 84)
            begin
                // broken frame: a few bits, then a long quiet stretch of ticks
                run_frame($urandom_range(1, 7));
                send_ticks($urandom_range(0, 40));
            end
            else if (pick < 98)
                // noise: short burst of arbitrary ticks and edges
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                wait_for_results();
        end
    endtask

    initial
    begin
        edge_decoder = new();
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = REG_RELOAD_PERIOD;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.action     = ACTION_TICK;
        item_ch.line_level = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset settings (period 10, late 8, wrap 2)
        send_ticks(1);              // plain tick, all result fields zero
        send_edge(1'b1);            // first edge of a frame, taken because armed
        send_ticks(3);
        send_edge(1'b0);            // count 3: neither late nor just after wrap, rejected
        send_ticks(5);
        send_edge(1'b0);            // count 8: late edge, taken
        send_edge(1'b0);            // count 0: taken on the wrap side
        send_edge(1'b1);
        send_edge(1'b0);
        send_edge(1'b1);
        send_edge(1'b0);
        send_edge(1'b0);            // eighth bit is 0: byte 94 out, trailing edge pending
        send_edge(1'b1);            // trailing edge still taken by timing, then re-arm
        send_ticks(2);
        send_edge(1'b1);            // re-armed block takes it regardless of count
        send_edge(1'b0);            // count 0, taken

        // random part over a range of register settings, extremes included
        run_phase(16'd10, 16'd8, 16'd2);
        run_phase(16'd3, 16'd2, 16'd0);          // counter left above the new period
        run_phase(16'd0, 16'd5, 16'd0);          // period zero: counter pinned at zero
        run_phase(16'hFFFF, 16'd0, 16'd0);       // late bound zero: every edge taken
        run_phase(16'hFFFF, 16'hFFFF, 16'd0);    // only armed or zero-count edges taken
        wait_for_results();
        write_cfg(REG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));  // must be ignored
        run_phase(16'd20, 16'd12, 16'hFFFF);     // wrap bound at max: every edge taken
        run_phase(16'd1, 16'd1, 16'd1);
        run_phase(16'd12, 16'd9, 16'd3);

        // drain, then wait on to catch any stray result
        wait_for_results();
        repeat (4) @(posedge clk);
        if (edge_decoder.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
